// ===== hw/rtl/uwa_pkg.sv =====
// ----------------------------------------------------------------------------
// uwa_pkg
// Shared types, constants and the arctangent table for the wall aligner.
// ----------------------------------------------------------------------------
package uwa_pkg;

  localparam int SENSOR_COUNT_DEF = 4;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int IDX_W      = 2;
  localparam int DIST_W     = 13;
  localparam int BASE_W     = 10;
  localparam int NEAR_W     = 13;
  localparam int THR_W      = 15;
  localparam int SPEED_W    = 8;
  localparam int ANGLE_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int DELTA_W    = DIST_W + 1;
  localparam int XY_W       = 32;
  localparam int Z_W        = 25;
  localparam int ATAN_W     = 23;
  localparam int ATAN_IDX_W = 5;

  localparam logic [BASE_W-1:0]  BASE_RST  = 10'd100;
  localparam logic [NEAR_W-1:0]  NEAR_RST  = 13'd1000;
  localparam logic [THR_W-1:0]   THR_RST   = 15'd2560;
  localparam logic [SPEED_W-1:0] SPEED_RST = 8'd30;

  localparam logic [CFG_IDX_W-1:0] REG_BASELINE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 2'd3;

  localparam logic CMD_ROTATE = 1'b0;
  localparam logic CMD_STOP   = 1'b1;

  localparam logic [8:0] MAX_DEG = 9'd90;

  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic busy;
    logic done;
  } uwa_cordic_stat_t;

  // Arctangent of 2^-i in degrees with 16 fractional bits.
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/uwa_in_if.sv =====
// ----------------------------------------------------------------------------
// uwa_in_if
// Reading channel: one sensor word per handshake.
// ----------------------------------------------------------------------------
interface uwa_in_if;
  logic                          valid;
  logic                          ready;
  logic [uwa_pkg::IDX_W-1:0]     sensor_index;
  logic [uwa_pkg::DIST_W-1:0]    distance_mm;
  logic                          robot_stopped;

  modport source (output valid, sensor_index, distance_mm, robot_stopped, input ready);
  modport sink   (input valid, sensor_index, distance_mm, robot_stopped, output ready);
endinterface

// ===== hw/rtl/uwa_out_if.sv =====
// ----------------------------------------------------------------------------
// uwa_out_if
// Command channel: one motion command word per handshake.
// ----------------------------------------------------------------------------
interface uwa_out_if;
  logic                               valid;
  logic                               ready;
  logic                               command;
  logic signed [uwa_pkg::ANGLE_W-1:0] turn_angle_deg;
  logic [uwa_pkg::SPEED_W-1:0]        speed;
  logic                               task_finished;

  modport source (output valid, command, turn_angle_deg, speed, task_finished, input ready);
  modport sink   (input valid, command, turn_angle_deg, speed, task_finished, output ready);
endinterface

// ===== hw/rtl/uwa_cordic.sv =====
// ----------------------------------------------------------------------------
// uwa_cordic
// Vectoring CORDIC, one rotation step per cycle, angle in degrees Q16.
// ----------------------------------------------------------------------------
module uwa_cordic #(
  parameter int CORDIC_STEPS = uwa_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [uwa_pkg::BASE_W-1:0]        base,
  input  logic signed [uwa_pkg::DELTA_W-1:0] delta,
  output uwa_pkg::uwa_cordic_stat_t         stat,
  output logic signed [uwa_pkg::Z_W-1:0]    z
);
  import uwa_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

  logic signed [XY_W-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic signed [Z_W-1:0]  z_r, z_nxt, a;
  logic [CNT_W-1:0]       step_r, step_nxt;
  logic                   busy_r, busy_nxt;
  logic                   last;

  assign last = (step_r == LAST);
  assign xs   = x_r >>> step_r;
  assign ys   = y_r >>> step_r;
  assign a    = $signed({2'b00, atan_q16(ATAN_IDX_W'(step_r))});

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      x_nxt    = $signed({{(XY_W-BASE_W-16){1'b0}}, base, 16'd0});
      y_nxt    = $signed({{(XY_W-DELTA_W-16){delta[DELTA_W-1]}}, delta, 16'd0});
      z_nxt    = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r < 0) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - a;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + a;
      end
      step_nxt = step_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && last;
  assign z         = z_r;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && step_r == '0)
    else $error("CORDIC did not begin at step zero");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done && !start |=> !busy_r)
    else $error("CORDIC kept running after its last step");
  a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !last && !start |=> busy_r && step_r == $past(step_r) + 1'b1)
    else $error("CORDIC step counter skipped");
`endif

endmodule

// ===== hw/rtl/ultrasonic_wall_align.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_wall_align
// Stores ultrasonic readings and, for each reading taken at rest, turns the side
// sensor difference near a wall into a rotate command, else gives a stop command.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// in_ch     sink       sensor_index, distance_mm, robot_stopped
// out_ch    source     command, turn_angle_deg, speed, task_finished
// cfg_*     write      cfg_index selects baseline, near limit, threshold, speed
//
// A reading taken while moving is stored and gives no word.
// A reading at rest gives one word via the check and finish states, and also
// via the calc state when an angle is needed, while the CORDIC unit runs one
// step per cycle; in_ch.ready is low meanwhile.
// Reset is synchronous; it clears the distance table and loads default registers.
// A waiting word stays in the output register; a new reading is taken
// meanwhile, and its word waits until the register is free.
// ----------------------------------------------------------------------------
module ultrasonic_wall_align #(
  parameter int SENSOR_COUNT = uwa_pkg::SENSOR_COUNT_DEF,
  parameter int CORDIC_STEPS = uwa_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  uwa_in_if.sink                         in_ch,
  uwa_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [uwa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uwa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import uwa_pkg::*;

  localparam int TAB_W = $clog2(SENSOR_COUNT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  dist_t              dist_r [SENSOR_COUNT];
  logic [BASE_W-1:0]  base_r;
  logic [NEAR_W-1:0]  near_r;
  logic [THR_W-1:0]   thr_r;
  logic [SPEED_W-1:0] speed_r;
  logic               use_cordic_r, use_cordic_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_cmd_r, out_cmd_nxt;
  logic signed [ANGLE_W-1:0] out_angle_r, out_angle_nxt;
  logic [SPEED_W-1:0]        out_speed_r, out_speed_nxt;
  logic                      out_fin_r, out_fin_nxt;

  logic                      in_acc;
  logic [TAB_W-1:0]          wr_idx;
  logic                      near;
  logic signed [DELTA_W-1:0] delta;
  logic                      cordic_start;
  uwa_cordic_stat_t          cstat;
  logic signed [Z_W-1:0]     z;
  logic [Z_W-1:0]            zabs;
  logic                      rotate;
  logic [8:0]                deg;
  logic [ANGLE_W-1:0]        deg_c;
  logic                      slot_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wr_idx      = TAB_W'(in_ch.sensor_index);

  assign near  = (dist_r[2] < near_r) && (dist_r[3] < near_r);
  assign delta = $signed({1'b0, dist_r[2]}) - $signed({1'b0, dist_r[3]});
  assign cordic_start = (state_r == ST_CHECK) && near && (delta != '0);

  uwa_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .base  (base_r),
    .delta (delta),
    .stat  (cstat),
    .z     (z)
  );

  assign zabs   = (z < 0) ? Z_W'(-z) : Z_W'(z);
  assign rotate = use_cordic_r && ({2'b00, thr_r} < zabs[Z_W-1:8]);
  assign deg    = zabs[Z_W-1:16];
  assign deg_c  = (deg > MAX_DEG) ? ANGLE_W'(MAX_DEG) : ANGLE_W'(deg);
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    use_cordic_nxt = use_cordic_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_cmd_nxt    = out_cmd_r;
    out_angle_nxt  = out_angle_r;
    out_speed_nxt  = out_speed_r;
    out_fin_nxt    = out_fin_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.robot_stopped) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        use_cordic_nxt = cordic_start;
        state_nxt      = cordic_start ? ST_CALC : ST_FIN;
      end
      ST_CALC: begin
        if (cstat.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (rotate) begin
            out_cmd_nxt   = CMD_ROTATE;
            out_angle_nxt = (z < 0) ? $signed(deg_c) : -$signed(deg_c);
            out_speed_nxt = speed_r;
            out_fin_nxt   = 1'b0;
          end else begin
            out_cmd_nxt   = CMD_STOP;
            out_angle_nxt = '0;
            out_speed_nxt = '0;
            out_fin_nxt   = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      use_cordic_r <= 1'b0;
      base_r       <= BASE_RST;
      near_r       <= NEAR_RST;
      thr_r        <= THR_RST;
      speed_r      <= SPEED_RST;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        dist_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      use_cordic_r <= use_cordic_nxt;
      if (in_acc) begin
        dist_r[wr_idx] <= in_ch.distance_mm;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASELINE:  base_r  <= cfg_data[BASE_W-1:0];
          REG_NEAR:      near_r  <= cfg_data[NEAR_W-1:0];
          REG_THRESHOLD: thr_r   <= cfg_data[THR_W-1:0];
          REG_SPEED:     speed_r <= cfg_data[SPEED_W-1:0];
        endcase
      end
    end
    out_cmd_r   <= out_cmd_nxt;
    out_angle_r <= out_angle_nxt;
    out_speed_r <= out_speed_nxt;
    out_fin_r   <= out_fin_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.command        = out_cmd_r;
  assign out_ch.turn_angle_deg = out_angle_r;
  assign out_ch.speed          = out_speed_r;
  assign out_ch.task_finished  = out_fin_r;

`ifndef SYNTHESIS
  a_moving_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_ch.robot_stopped |=> state_r == ST_IDLE)
    else $error("Reading taken while moving started work");
  a_stopped_checks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.robot_stopped |=> state_r == ST_CHECK)
    else $error("Reading taken at rest did not start a check");
  a_calc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CALC |-> cstat.busy)
    else $error("Waiting on an idle CORDIC unit");
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cmd_r == CMD_ROTATE |->
      out_angle_r <= 8'sd90 && out_angle_r >= -8'sd90)
    else $error("Rotate angle out of range");
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && slot_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("Finished word was not loaded");
`endif

endmodule
